// File: design/lrs_pkg.sv
// ----------------------------------------------------------------------------
// lrs_pkg: shared types and helpers for the instruction sequencer
// Holds the architectural state record, access kinds and register helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lrs_pkg;

   // Register pair slots.
   localparam int RP_AF = 0;
   localparam int RP_BC = 1;
   localparam int RP_DE = 2;
   localparam int RP_HL = 3;
   localparam int RP_SP = 4;
   localparam int RP_PC = 5;

   // Flag masks in the low byte of AF.
   localparam logic [7:0] FLAG_Z = 8'h80;
   localparam logic [7:0] FLAG_N = 8'h40;
   localparam logic [7:0] FLAG_H = 8'h20;
   localparam logic [7:0] FLAG_C = 8'h10;

   // Width of the packed result beat.
   localparam int RSP_BITS = 128;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_IO    = 2'd2,
      KIND_HALT  = 2'd3
   } kind_type;

   typedef logic [5:0][15:0] rp_type;

   typedef struct packed {
      rp_type     rp;
      logic       ie;
      logic [3:0] step;
      logic [7:0] opcode;
      logic [7:0] op_lo;
      logic       halted;
      kind_type   kind;
      logic [15:0] paddr;
      logic [7:0] pdata;
   } state_type;

   // Read an 8-bit register by its three-bit code; (HL) reads as zero.
   function automatic logic [7:0] get8(rp_type rp, logic [2:0] code);
      logic [7:0] v;
      v = 8'h00;
      unique case (code)
         3'd0: v = rp[RP_BC][15:8];
         3'd1: v = rp[RP_BC][7:0];
         3'd2: v = rp[RP_DE][15:8];
         3'd3: v = rp[RP_DE][7:0];
         3'd4: v = rp[RP_HL][15:8];
         3'd5: v = rp[RP_HL][7:0];
         3'd7: v = rp[RP_AF][15:8];
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   // Write an 8-bit register by its three-bit code.
   function automatic rp_type set8(rp_type rp, logic [2:0] code, logic [7:0] v);
      rp_type r;
      r = rp;
      unique case (code)
         3'd0: r[RP_BC][15:8] = v;
         3'd1: r[RP_BC][7:0]  = v;
         3'd2: r[RP_DE][15:8] = v;
         3'd3: r[RP_DE][7:0]  = v;
         3'd4: r[RP_HL][15:8] = v;
         3'd5: r[RP_HL][7:0]  = v;
         3'd7: r[RP_AF][15:8] = v;
         default: r = rp;
      endcase
      return r;
   endfunction

   // Set or clear one flag; the low nibble of F always reads zero.
   function automatic logic [15:0] flag(logic [15:0] af, logic [7:0] mask, logic v);
      logic [15:0] r;
      r = v ? (af | {8'h00, mask}) : (af & ~{8'h00, mask});
      return r & 16'hfff0;
   endfunction

   // Schedule the next access and advance the micro-step.
   function automatic state_type sched(state_type st, logic [3:0] s, kind_type k,
                                       logic [15:0] addr, logic [7:0] dat);
      state_type r;
      r = st;
      r.kind  = k;
      r.paddr = addr;
      r.pdata = dat;
      r.step  = s + 4'd1;
      return r;
   endfunction

   function automatic state_type rd_pc(state_type st, logic [3:0] s);
      state_type r;
      logic [15:0] a;
      r = st;
      a = r.rp[RP_PC];
      r.rp[RP_PC] = a + 16'd1;
      return sched(r, s, KIND_READ, a, 8'h00);
   endfunction

   function automatic state_type rd_sp(state_type st, logic [3:0] s);
      state_type r;
      logic [15:0] a;
      r = st;
      a = r.rp[RP_SP];
      r.rp[RP_SP] = a + 16'd1;
      return sched(r, s, KIND_READ, a, 8'h00);
   endfunction

   // Pre-decrement SP and write one byte.
   function automatic state_type wr_push(state_type st, logic [3:0] s, logic [7:0] v);
      state_type r;
      r = st;
      r.rp[RP_SP] = r.rp[RP_SP] - 16'd1;
      return sched(r, s, KIND_WRITE, r.rp[RP_SP], v);
   endfunction

   // Finish the instruction: the next access fetches an opcode at PC.
   function automatic state_type done(state_type st);
      state_type r;
      r = st;
      r.step  = 4'd0;
      r.kind  = KIND_READ;
      r.paddr = r.rp[RP_PC];
      r.pdata = 8'h00;
      return r;
   endfunction

   // Unknown opcode: back PC up to it and stop for good.
   function automatic state_type halt_core(state_type st);
      state_type r;
      r = st;
      r.rp[RP_PC] = r.rp[RP_PC] - 16'd1;
      r.halted = 1'b1;
      r.step   = 4'd0;
      r.kind   = KIND_HALT;
      r.paddr  = 16'h0000;
      r.pdata  = 8'h00;
      return r;
   endfunction

   // Load A with a logic result and set the flags.
   function automatic state_type set_a_logic(state_type st, logic [7:0] v, logic h);
      state_type r;
      r = st;
      r.rp = set8(r.rp, 3'd7, v);
      r.rp[RP_AF] = flag(r.rp[RP_AF], FLAG_Z, v == 8'h00);
      r.rp[RP_AF] = flag(r.rp[RP_AF], FLAG_N, 1'b0);
      r.rp[RP_AF] = flag(r.rp[RP_AF], FLAG_H, h);
      r.rp[RP_AF] = flag(r.rp[RP_AF], FLAG_C, 1'b0);
      return r;
   endfunction

endpackage
`default_nettype wire

// File: design/lr35902_instruction_sequencer.sv
// ----------------------------------------------------------------------------
// lr35902_instruction_sequencer: bus-cycle sequencer for a small 8-bit core
// One input beat completes a bus access; one result beat reports the next.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  req_    | in        | read data for the pending access
//  rsp_    | out       | next access and current register file
//  csr_    | in        | start address for the first fetch
//
// The next state is computed in one pass from the state registers and lands
// in the result register, so a beat is accepted in every cycle while the
// result register is empty or being drained.
// Reset clears all but the result payload; PC and first fetch address come
// from the start address, which a write changes only before the first beat.
// A stalled result holds its data; req_tready drops only while it waits.
`timescale 1ns / 1ps
`default_nettype none
module lr35902_instruction_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // read_data[7:0]
   input  wire logic [7:0]  req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // access_kind[1:0], access_address[17:2], write_data[25:18],
   // opcode_fetch[26], reg_af[42:27], reg_bc[58:43], reg_de[74:59],
   // reg_hl[90:75], reg_sp[106:91], reg_pc[122:107], irq_enabled[123]
   output logic [lrs_pkg::RSP_BITS-1:0] rsp_tdata,
   input  wire logic        csr_wen,
   input  wire logic [15:0] csr_wdata
);
   import lrs_pkg::*;

   state_type st_ff;
   state_type st_in;
   logic      stepped_ff;
   logic      rsp_tvalid_ff;
   logic [RSP_BITS-1:0] rsp_tdata_ff;
   logic [RSP_BITS-1:0] rsp_tdata_in;
   logic      accept;
   logic      fetch;
   logic [15:0] out_addr;
   logic [7:0]  out_wdata;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   lrs_exec u_exec (
      .cur_i  (st_ff),
      .data_i (req_tdata),
      .nxt_o  (st_in)
   );

   // Pack the result beat from the state after this cycle.
   always_comb begin
      fetch     = !st_in.halted && (st_in.step == 4'd0);
      out_addr  = (st_in.kind == KIND_READ || st_in.kind == KIND_WRITE) ? st_in.paddr : 16'h0;
      out_wdata = (st_in.kind == KIND_WRITE) ? st_in.pdata : 8'h00;
      rsp_tdata_in = {4'h0, st_in.ie, st_in.rp[RP_PC], st_in.rp[RP_SP], st_in.rp[RP_HL],
                      st_in.rp[RP_DE], st_in.rp[RP_BC], st_in.rp[RP_AF], fetch, out_wdata,
                      out_addr, st_in.kind};
   end

   // State registers and start address load; the cleared state already
   // holds an opcode fetch as the pending access.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= '0;
         stepped_ff <= 1'b0;
      end else if (accept) begin
         st_ff      <= st_in;
         stepped_ff <= 1'b1;
      end else if (csr_wen && !stepped_ff) begin
         st_ff.rp[RP_PC] <= csr_wdata;
         st_ff.paddr     <= csr_wdata;
      end
   end

   // Result register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (accept) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
`default_nettype wire

// File: design/lrs_exec.sv
// ----------------------------------------------------------------------------
// lrs_exec: next-state logic for one bus cycle
// Completes the pending access and computes the state after one micro-step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lrs_exec (
   input  wire lrs_pkg::state_type cur_i,
   input  wire logic [7:0]         data_i,
   output lrs_pkg::state_type      nxt_o
);
   import lrs_pkg::*;

   state_type   st;
   logic [7:0]  op;
   logic [7:0]  d;
   logic [3:0]  s;
   logic [7:0]  a;
   logic [7:0]  v8;
   logic [7:0]  cb_v;
   logic [2:0]  pr;
   logic [2:0]  pp;
   logic [8:0]  sum9;
   logic [16:0] sum17;
   logic [15:0] v16;
   logic [15:0] ret;
   logic [2:0]  grp;
   logic [2:0]  bsel;
   logic        dec;

   always_comb begin
      st    = cur_i;
      s     = cur_i.step;
      d     = (cur_i.kind == KIND_READ) ? data_i : 8'h00;
      op    = cur_i.opcode;
      a     = 8'h00;
      v8    = 8'h00;
      cb_v  = 8'h00;
      pr    = 3'd0;
      pp    = 3'd0;
      sum9  = 9'd0;
      sum17 = 17'd0;
      v16   = 16'h0000;
      ret   = 16'h0000;
      grp   = 3'd0;
      bsel  = 3'd0;
      dec   = 1'b0;
      if (!cur_i.halted) begin
         // Opcode fetch beat: latch the opcode and step past it.
         if (cur_i.step == 4'd0) begin
            st.opcode = d;
            op        = d;
            st.rp[RP_PC] = st.rp[RP_PC] + 16'd1;
            s = 4'd0;
            d = 8'h00;
         end
         a    = st.rp[RP_AF][15:8];
         pr   = {1'b0, op[5:4]} + 3'd1;
         pp   = {1'b0, op[5:4] + 2'd1};
         grp  = op[5:3];
         // Instruction decode in the order that decides precedence.
         priority if (op == 8'hcb) begin
            if (s == 4'd0) begin
               st = rd_pc(st, 4'd0);
            end else begin
               bsel = d[5:3];
               cb_v = get8(st.rp, d[2:0]);
               if (d == 8'h37) begin
                  st = set_a_logic(st, {cb_v[3:0], cb_v[7:4]}, 1'b0);
                  st = done(st);
               end else if (d >= 8'h40 && d[2:0] != 3'd6) begin
                  unique case (d[7:6])
                     2'd1: begin
                        st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_Z, !cb_v[bsel]);
                        st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_N, 1'b0);
                        st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_H, 1'b1);
                     end
                     2'd2: st.rp = set8(st.rp, d[2:0], cb_v & ~(8'h01 << bsel));
                     default: st.rp = set8(st.rp, d[2:0], cb_v | (8'h01 << bsel));
                  endcase
                  st = done(st);
               end else begin
                  st = halt_core(st);
               end
            end
         end else if (op >= 8'h40 && op <= 8'h7f && !(op >= 8'h70 && op <= 8'h77)) begin
            // Register loads, including from (HL).
            if (op[2:0] != 3'd6) begin
               st.rp = set8(st.rp, op[5:3], get8(st.rp, op[2:0]));
               st = done(st);
            end else if (s == 4'd0) begin
               st = sched(st, 4'd0, KIND_READ, st.rp[RP_HL], 8'h00);
            end else begin
               st.rp = set8(st.rp, op[5:3], d);
               st = done(st);
            end
         end else if (op >= 8'h80 && op <= 8'hbf && op[2:0] != 3'd6) begin
            // Accumulator arithmetic and logic on a register.
            v8 = get8(st.rp, op[2:0]);
            if (grp == 3'd0) begin
               sum9 = {1'b0, a} + {1'b0, v8};
               st.rp = set8(st.rp, 3'd7, sum9[7:0]);
               st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_Z, sum9[7:0] == 8'h00);
               st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_N, 1'b0);
               st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_H,
                                   ({1'b0, a[3:0]} + {1'b0, v8[3:0]}) > 5'h0f);
               st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_C, sum9[8]);
               st = done(st);
            end else if (grp == 3'd4) begin
               st = done(set_a_logic(st, a & v8, 1'b1));
            end else if (grp == 3'd5) begin
               st = done(set_a_logic(st, a ^ v8, 1'b0));
            end else if (grp == 3'd6) begin
               st = done(set_a_logic(st, a | v8, 1'b0));
            end else begin
               st = halt_core(st);
            end
         end else if (op < 8'h40 && op[3:0] == 4'h1) begin
            // 16-bit immediate load.
            if (s == 4'd0) begin
               st = rd_pc(st, 4'd0);
            end else if (s == 4'd1) begin
               st.op_lo = d;
               st = rd_pc(st, 4'd1);
            end else begin
               st.rp[pr] = {d, st.op_lo};
               st = done(st);
            end
         end else if (op < 8'h40 && (op[3:0] == 4'h3 || op[3:0] == 4'hb)) begin
            st.rp[pr] = op[3] ? st.rp[pr] - 16'd1 : st.rp[pr] + 16'd1;
            st = done(st);
         end else if (op < 8'h40 && op[3:0] == 4'h9) begin
            // 16-bit add into HL.
            v16   = st.rp[pr];
            sum17 = {1'b0, st.rp[RP_HL]} + {1'b0, v16};
            st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_N, 1'b0);
            st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_H,
                                ({1'b0, st.rp[RP_HL][11:0]} + {1'b0, v16[11:0]}) > 13'h0fff);
            st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_C, sum17[16]);
            st.rp[RP_HL] = sum17[15:0];
            st = done(st);
         end else if (op < 8'h40 && op[2:0] == 3'd6 && op != 8'h36) begin
            if (s == 4'd0) begin
               st = rd_pc(st, 4'd0);
            end else begin
               st.rp = set8(st.rp, op[5:3], d);
               st = done(st);
            end
         end else if (op >= 8'hc0 && op[3:0] == 4'h1) begin
            // Pop.
            if (s == 4'd0) begin
               st = rd_sp(st, 4'd0);
            end else if (s == 4'd1) begin
               st.op_lo = d;
               st = rd_sp(st, 4'd1);
            end else begin
               v16 = {d, st.op_lo};
               if (pp == 3'd0) begin
                  v16 = v16 & 16'hfff0;
               end
               st.rp[pp] = v16;
               st = done(st);
            end
         end else if (op >= 8'hc0 && op[3:0] == 4'h5) begin
            // Push.
            v16 = st.rp[pp];
            if (s == 4'd0) begin
               st = wr_push(st, 4'd0, v16[15:8]);
            end else if (s == 4'd1) begin
               st = wr_push(st, 4'd1, v16[7:0]);
            end else if (s == 4'd2) begin
               st = sched(st, 4'd2, KIND_IO, 16'h0000, 8'h00);
            end else begin
               st = done(st);
            end
         end else if (op >= 8'hc0 && op[2:0] == 3'd7) begin
            // Restart vector call.
            v16 = st.rp[RP_PC];
            if (s == 4'd0) begin
               st = wr_push(st, 4'd0, v16[15:8]);
            end else if (s == 4'd1) begin
               st = wr_push(st, 4'd1, v16[7:0]);
            end else if (s == 4'd2) begin
               st.rp[RP_PC] = {8'h00, op & 8'h38};
               st = sched(st, 4'd2, KIND_IO, 16'h0000, 8'h00);
            end else begin
               st = done(st);
            end
         end else if (op == 8'h00) begin
            st = done(st);
         end else if (op == 8'h0c || op == 8'h05 || op == 8'h0d) begin
            dec = op[0];
            v8  = get8(st.rp, op[5:3]) + (dec ? 8'hff : 8'h01);
            st.rp = set8(st.rp, op[5:3], v8);
            st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_Z, v8 == 8'h00);
            st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_N, dec);
            st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_H, v8[3:0] == (dec ? 4'hf : 4'h0));
            st = done(st);
         end else if (op == 8'h20) begin
            // Relative jump when Z is clear.
            if (s == 4'd0) begin
               st = rd_pc(st, 4'd0);
            end else if (s == 4'd1 && !st.rp[RP_AF][7]) begin
               st.rp[RP_PC] = st.rp[RP_PC] + {{8{d[7]}}, d};
               st = sched(st, 4'd1, KIND_IO, 16'h0000, 8'h00);
            end else begin
               st = done(st);
            end
         end else if (op == 8'h2a) begin
            if (s == 4'd0) begin
               st = sched(st, 4'd0, KIND_READ, st.rp[RP_HL], 8'h00);
            end else begin
               st.rp = set8(st.rp, 3'd7, d);
               st.rp[RP_HL] = st.rp[RP_HL] + 16'd1;
               st = done(st);
            end
         end else if (op == 8'h2f) begin
            st.rp = set8(st.rp, 3'd7, ~a);
            st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_N, 1'b1);
            st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_H, 1'b1);
            st = done(st);
         end else if (op == 8'h32) begin
            if (s == 4'd0) begin
               st = sched(st, 4'd0, KIND_WRITE, st.rp[RP_HL], a);
            end else begin
               st.rp[RP_HL] = st.rp[RP_HL] - 16'd1;
               st = done(st);
            end
         end else if (op == 8'h36) begin
            if (s == 4'd0) begin
               st = rd_pc(st, 4'd0);
            end else if (s == 4'd1) begin
               st = sched(st, 4'd1, KIND_WRITE, st.rp[RP_HL], d);
            end else begin
               st = done(st);
            end
         end else if (op == 8'hc3 || op == 8'hc9) begin
            // Absolute jump or return: two operand bytes, then an idle access.
            if (s == 4'd0) begin
               st = (op == 8'hc3) ? rd_pc(st, 4'd0) : rd_sp(st, 4'd0);
            end else if (s == 4'd1) begin
               st.op_lo = d;
               st = (op == 8'hc3) ? rd_pc(st, 4'd1) : rd_sp(st, 4'd1);
            end else if (s == 4'd2) begin
               st.rp[RP_PC] = {d, st.op_lo};
               st = sched(st, 4'd2, KIND_IO, 16'h0000, 8'h00);
            end else begin
               st = done(st);
            end
         end else if (op == 8'hcd) begin
            // Call pushes the return address before it reads the target.
            ret = st.rp[RP_PC] + 16'd2;
            if (s == 4'd0) begin
               st = wr_push(st, 4'd0, ret[15:8]);
            end else if (s == 4'd1) begin
               st = wr_push(st, 4'd1, ret[7:0]);
            end else if (s == 4'd2) begin
               st = rd_pc(st, 4'd2);
            end else if (s == 4'd3) begin
               st.op_lo = d;
               st = rd_pc(st, 4'd3);
            end else if (s == 4'd4) begin
               st.rp[RP_PC] = {d, st.op_lo};
               st = sched(st, 4'd4, KIND_IO, 16'h0000, 8'h00);
            end else begin
               st = done(st);
            end
         end else if (op == 8'he0) begin
            if (s == 4'd0) begin
               st = rd_pc(st, 4'd0);
            end else if (s == 4'd1) begin
               st = sched(st, 4'd1, KIND_WRITE, {8'hff, d}, a);
            end else begin
               st = done(st);
            end
         end else if (op == 8'he2) begin
            if (s == 4'd0) begin
               st = sched(st, 4'd0, KIND_WRITE, {8'hff, st.rp[RP_BC][7:0]}, a);
            end else begin
               st = done(st);
            end
         end else if (op == 8'he6) begin
            if (s == 4'd0) begin
               st = rd_pc(st, 4'd0);
            end else begin
               st = done(set_a_logic(st, a & d, 1'b1));
            end
         end else if (op == 8'he9) begin
            st.rp[RP_PC] = st.rp[RP_HL];
            st = done(st);
         end else if (op == 8'hea) begin
            if (s == 4'd0) begin
               st = rd_pc(st, 4'd0);
            end else if (s == 4'd1) begin
               st.op_lo = d;
               st = rd_pc(st, 4'd1);
            end else if (s == 4'd2) begin
               st = sched(st, 4'd2, KIND_WRITE, {d, st.op_lo}, a);
            end else begin
               st = done(st);
            end
         end else if (op == 8'hf0) begin
            if (s == 4'd0) begin
               st = rd_pc(st, 4'd0);
            end else if (s == 4'd1) begin
               st = sched(st, 4'd1, KIND_READ, {8'hff, d}, 8'h00);
            end else begin
               st.rp = set8(st.rp, 3'd7, d);
               st = done(st);
            end
         end else if (op == 8'hf3 || op == 8'hfb) begin
            st.ie = op[3];
            st = done(st);
         end else if (op == 8'hfe) begin
            // Compare with immediate.
            if (s == 4'd0) begin
               st = rd_pc(st, 4'd0);
            end else begin
               st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_Z, a == d);
               st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_N, 1'b1);
               st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_H, a[3:0] < d[3:0]);
               st.rp[RP_AF] = flag(st.rp[RP_AF], FLAG_C, a < d);
               st = done(st);
            end
         end else begin
            st = halt_core(st);
         end
      end
      nxt_o = st;
   end

endmodule
`default_nettype wire

// File: design/lrs_checker.sv
// ----------------------------------------------------------------------------
// lrs_port_checks: port-level checks for the instruction sequencer
// Watches the handshakes on both channels and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lrs_port_checks (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [lrs_pkg::RSP_BITS-1:0] rsp_tdata
);

   // A stalled result beat stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   // A stalled result beat keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result payload changed while stalled");

   // Every accepted input beat yields a result beat in the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted beat produced no result");

   // An empty result register never holds off the input.
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

endmodule

bind lr35902_instruction_sequencer lrs_port_checks u_port_checks (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// File: bench/tb_lrs_ops_pkg.sv
// ----------------------------------------------------------------------------
// tb_lrs_ops_pkg: opcode names shared by the sequencer testbench
// Main and prefixed opcodes that the checker and the stimulus refer to.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tb_lrs_ops_pkg;

   localparam logic [7:0] OP_NOP           = 8'h00;
   localparam logic [7:0] OP_DEC_B         = 8'h05;
   localparam logic [7:0] OP_INC_C         = 8'h0c;
   localparam logic [7:0] OP_DEC_C         = 8'h0d;
   localparam logic [7:0] OP_JR_NZ         = 8'h20;
   localparam logic [7:0] OP_LOAD_A_HL_INC = 8'h2a;
   localparam logic [7:0] OP_CPL           = 8'h2f;
   localparam logic [7:0] OP_STORE_HL_DEC  = 8'h32;
   localparam logic [7:0] OP_STORE_HL_IMM  = 8'h36;
   localparam logic [7:0] OP_JP            = 8'hc3;
   localparam logic [7:0] OP_RET           = 8'hc9;
   localparam logic [7:0] OP_PREFIX        = 8'hcb;
   localparam logic [7:0] OP_CALL          = 8'hcd;
   localparam logic [7:0] OP_LDH_N_A       = 8'he0;
   localparam logic [7:0] OP_LDH_C_A       = 8'he2;
   localparam logic [7:0] OP_AND_IMM       = 8'he6;
   localparam logic [7:0] OP_JUMP_HL       = 8'he9;
   localparam logic [7:0] OP_STORE_ABS_A   = 8'hea;
   localparam logic [7:0] OP_LDH_A_N       = 8'hf0;
   localparam logic [7:0] OP_DI            = 8'hf3;
   localparam logic [7:0] OP_EI            = 8'hfb;
   localparam logic [7:0] OP_CP_N          = 8'hfe;
   // An opcode the core does not implement; it stops the core.
   localparam logic [7:0] OP_ILLEGAL       = 8'hd3;
   // Prefixed nibble swap of A.
   localparam logic [7:0] CB_SWAP_A        = 8'h37;

endpackage

// File: bench/lrs_checker.sv
// ----------------------------------------------------------------------------
// lrs_checker: predicts and checks the sequencer's result beats
// Tracks the core state per accepted input beat and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lrs_checker
   import lrs_pkg::*;
   import tb_lrs_ops_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,
   input  logic         csr_wen,
   input  logic [15:0]  csr_wdata,
   output int           fail_count,
   output int           waiting,
   output logic         next_fetch,
   output logic         next_read,
   output logic         next_prefixed,
   output logic         core_halted
);

   typedef struct packed {
      kind_type    kind;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic        fetch;
      logic [15:0] af, bc, de, hl, sp, pc;
      logic        ie;
   } bus_view_type;

   // Predicted core state.
   logic [15:0] rp [6];
   logic        ie_q, halted_q, stepped_q;
   logic [3:0]  step_q;
   logic [7:0]  opcode_q, op_lo_q, pdata_q;
   kind_type    kind_q;
   logic [15:0] paddr_q, start_q;

   bus_view_type expected_bus[$];

   function automatic logic [7:0] reg_rd(logic [2:0] code);
      case (code)
         3'd0: return rp[RP_BC][15:8];
         3'd1: return rp[RP_BC][7:0];
         3'd2: return rp[RP_DE][15:8];
         3'd3: return rp[RP_DE][7:0];
         3'd4: return rp[RP_HL][15:8];
         3'd5: return rp[RP_HL][7:0];
         3'd7: return rp[RP_AF][15:8];
         default: return 8'h00;
      endcase
   endfunction

   task automatic reg_wr(logic [2:0] code, logic [7:0] v);
      case (code)
         3'd0: rp[RP_BC][15:8] = v;
         3'd1: rp[RP_BC][7:0]  = v;
         3'd2: rp[RP_DE][15:8] = v;
         3'd3: rp[RP_DE][7:0]  = v;
         3'd4: rp[RP_HL][15:8] = v;
         3'd5: rp[RP_HL][7:0]  = v;
         3'd7: rp[RP_AF][15:8] = v;
         default: ;
      endcase
   endtask

   task automatic set_flag(logic [7:0] mask, logic v);
      rp[RP_AF] = v ? (rp[RP_AF] | {8'h00, mask}) : (rp[RP_AF] & ~{8'h00, mask});
      rp[RP_AF] = rp[RP_AF] & 16'hfff0;
   endtask

   task automatic schedule(logic [3:0] s, kind_type k, logic [15:0] addr, logic [7:0] dat);
      kind_q  = k;
      paddr_q = addr;
      pdata_q = dat;
      step_q  = s + 4'd1;
   endtask

   task automatic read_pc(logic [3:0] s);
      logic [15:0] a;
      a = rp[RP_PC];
      rp[RP_PC] = a + 16'd1;
      schedule(s, KIND_READ, a, 8'h00);
   endtask

   task automatic read_sp(logic [3:0] s);
      logic [15:0] a;
      a = rp[RP_SP];
      rp[RP_SP] = a + 16'd1;
      schedule(s, KIND_READ, a, 8'h00);
   endtask

   task automatic push_byte(logic [3:0] s, logic [7:0] v);
      rp[RP_SP] = rp[RP_SP] - 16'd1;
      schedule(s, KIND_WRITE, rp[RP_SP], v);
   endtask

   // Next access is the opcode fetch at PC.
   task automatic finish_op();
      step_q  = 4'd0;
      kind_q  = KIND_READ;
      paddr_q = rp[RP_PC];
      pdata_q = 8'h00;
   endtask

   task automatic stop_core();
      rp[RP_PC] = rp[RP_PC] - 16'd1;
      halted_q = 1'b1;
      step_q   = 4'd0;
      kind_q   = KIND_HALT;
      paddr_q  = 16'h0000;
      pdata_q  = 8'h00;
   endtask

   task automatic load_a_logic(logic [7:0] v, logic h);
      reg_wr(3'd7, v);
      set_flag(FLAG_Z, v == 8'h00);
      set_flag(FLAG_N, 1'b0);
      set_flag(FLAG_H, h);
      set_flag(FLAG_C, 1'b0);
   endtask

   // Second byte of a prefixed instruction.
   task automatic exec_prefixed(logic [7:0] op);
      logic [2:0] r, b;
      logic [7:0] v;
      r = op[2:0];
      b = op[5:3];
      v = reg_rd(r);
      if (op == CB_SWAP_A) begin
         load_a_logic({v[3:0], v[7:4]}, 1'b0);
      end else if (op >= 8'h40 && r != 3'd6) begin
         case (op[7:6])
            2'd1: begin
               set_flag(FLAG_Z, !v[b]);
               set_flag(FLAG_N, 1'b0);
               set_flag(FLAG_H, 1'b1);
            end
            2'd2: reg_wr(r, v & ~(8'h01 << b));
            default: reg_wr(r, v | (8'h01 << b));
         endcase
      end else begin
         stop_core();
         return;
      end
      finish_op();
   endtask

   // One micro-step of the current instruction with the data of its access.
   task automatic exec_step(logic [3:0] s, logic [7:0] d);
      logic [7:0]  op, a, v;
      logic [1:0]  idx, p;
      logic [8:0]  sum8;
      logic [4:0]  half8;
      logic [16:0] sum16;
      logic [12:0] half16;
      logic [15:0] w;
      logic        dec;
      op  = opcode_q;
      a   = rp[RP_AF][15:8];
      idx = op[5:4];
      p   = idx + 2'd1;
      if (op == OP_PREFIX) begin
         if (s == 0) read_pc(0); else exec_prefixed(d);
         return;
      end
      // Register loads, including the loads from (HL).
      if (op >= 8'h40 && op <= 8'h7f && !(op >= 8'h70 && op <= 8'h77)) begin
         if (op[2:0] != 3'd6) begin
            reg_wr(op[5:3], reg_rd(op[2:0]));
            finish_op();
         end else if (s == 0) schedule(0, KIND_READ, rp[RP_HL], 8'h00);
         else begin
            reg_wr(op[5:3], d);
            finish_op();
         end
         return;
      end
      // Accumulator arithmetic and logic on registers.
      if (op >= 8'h80 && op <= 8'hbf && op[2:0] != 3'd6) begin
         v = reg_rd(op[2:0]);
         case (op[5:3])
            3'd0: begin
               sum8  = {1'b0, a} + {1'b0, v};
               half8 = {1'b0, a[3:0]} + {1'b0, v[3:0]};
               reg_wr(3'd7, sum8[7:0]);
               set_flag(FLAG_Z, sum8[7:0] == 8'h00);
               set_flag(FLAG_N, 1'b0);
               set_flag(FLAG_H, half8[4]);
               set_flag(FLAG_C, sum8[8]);
            end
            3'd4: load_a_logic(a & v, 1'b1);
            3'd5: load_a_logic(a ^ v, 1'b0);
            3'd6: load_a_logic(a | v, 1'b0);
            default: begin
               stop_core();
               return;
            end
         endcase
         finish_op();
         return;
      end
      if (op < 8'h40 && op[3:0] == 4'h1) begin
         if (s == 0) read_pc(0);
         else if (s == 1) begin
            op_lo_q = d;
            read_pc(1);
         end else begin
            rp[int'(idx) + 1] = {d, op_lo_q};
            finish_op();
         end
         return;
      end
      if (op < 8'h40 && (op[3:0] == 4'h3 || op[3:0] == 4'hb)) begin
         rp[int'(idx) + 1] = op[3] ? rp[int'(idx) + 1] - 16'd1 : rp[int'(idx) + 1] + 16'd1;
         finish_op();
         return;
      end
      if (op < 8'h40 && op[3:0] == 4'h9) begin
         w      = rp[int'(idx) + 1];
         sum16  = {1'b0, rp[RP_HL]} + {1'b0, w};
         half16 = {1'b0, rp[RP_HL][11:0]} + {1'b0, w[11:0]};
         rp[RP_HL] = sum16[15:0];
         set_flag(FLAG_N, 1'b0);
         set_flag(FLAG_H, half16[12]);
         set_flag(FLAG_C, sum16[16]);
         finish_op();
         return;
      end
      if (op < 8'h40 && op[2:0] == 3'd6 && op != OP_STORE_HL_IMM) begin
         if (s == 0) read_pc(0);
         else begin
            reg_wr(op[5:3], d);
            finish_op();
         end
         return;
      end
      // Pop: the pair after AF wraps back to AF.
      if (op >= 8'hc0 && op[3:0] == 4'h1) begin
         if (s == 0) read_sp(0);
         else if (s == 1) begin
            op_lo_q = d;
            read_sp(1);
         end else begin
            w = {d, op_lo_q};
            if (p == 2'(RP_AF)) w = w & 16'hfff0;
            rp[p] = w;
            finish_op();
         end
         return;
      end
      if (op >= 8'hc0 && op[3:0] == 4'h5) begin
         w = rp[p];
         if (s == 0) push_byte(0, w[15:8]);
         else if (s == 1) push_byte(1, w[7:0]);
         else if (s == 2) schedule(2, KIND_IO, 16'h0000, 8'h00);
         else finish_op();
         return;
      end
      // Restart: push PC, then jump to the vector in the opcode.
      if (op >= 8'hc0 && op[2:0] == 3'd7) begin
         w = rp[RP_PC];
         if (s == 0) push_byte(0, w[15:8]);
         else if (s == 1) push_byte(1, w[7:0]);
         else if (s == 2) begin
            rp[RP_PC] = {8'h00, op & 8'h38};
            schedule(2, KIND_IO, 16'h0000, 8'h00);
         end else finish_op();
         return;
      end
      case (op)
         OP_NOP: finish_op();
         OP_INC_C, OP_DEC_B, OP_DEC_C: begin
            dec = op[0];
            v   = reg_rd(op[5:3]) + (dec ? 8'hff : 8'h01);
            reg_wr(op[5:3], v);
            set_flag(FLAG_Z, v == 8'h00);
            set_flag(FLAG_N, dec);
            set_flag(FLAG_H, v[3:0] == (dec ? 4'hf : 4'h0));
            finish_op();
         end
         OP_JR_NZ: begin
            if (s == 0) read_pc(0);
            else if (s == 1 && (rp[RP_AF][7:0] & FLAG_Z) == 8'h00) begin
               rp[RP_PC] = rp[RP_PC] + {{8{d[7]}}, d};
               schedule(1, KIND_IO, 16'h0000, 8'h00);
            end else finish_op();
         end
         OP_LOAD_A_HL_INC: begin
            if (s == 0) schedule(0, KIND_READ, rp[RP_HL], 8'h00);
            else begin
               reg_wr(3'd7, d);
               rp[RP_HL] = rp[RP_HL] + 16'd1;
               finish_op();
            end
         end
         OP_CPL: begin
            reg_wr(3'd7, ~a);
            set_flag(FLAG_N, 1'b1);
            set_flag(FLAG_H, 1'b1);
            finish_op();
         end
         OP_STORE_HL_DEC: begin
            if (s == 0) schedule(0, KIND_WRITE, rp[RP_HL], a);
            else begin
               rp[RP_HL] = rp[RP_HL] - 16'd1;
               finish_op();
            end
         end
         OP_STORE_HL_IMM: begin
            if (s == 0) read_pc(0);
            else if (s == 1) schedule(1, KIND_WRITE, rp[RP_HL], d);
            else finish_op();
         end
         OP_JP, OP_RET: begin
            if (s == 0) begin
               if (op == OP_JP) read_pc(0); else read_sp(0);
            end else if (s == 1) begin
               op_lo_q = d;
               if (op == OP_JP) read_pc(1); else read_sp(1);
            end else if (s == 2) begin
               rp[RP_PC] = {d, op_lo_q};
               schedule(2, KIND_IO, 16'h0000, 8'h00);
            end else finish_op();
         end
         OP_CALL: begin
            // The return address skips the two target bytes.
            w = rp[RP_PC] + 16'd2;
            if (s == 0) push_byte(0, w[15:8]);
            else if (s == 1) push_byte(1, w[7:0]);
            else if (s == 2) read_pc(2);
            else if (s == 3) begin
               op_lo_q = d;
               read_pc(3);
            end else if (s == 4) begin
               rp[RP_PC] = {d, op_lo_q};
               schedule(4, KIND_IO, 16'h0000, 8'h00);
            end else finish_op();
         end
         OP_LDH_N_A: begin
            if (s == 0) read_pc(0);
            else if (s == 1) schedule(1, KIND_WRITE, {8'hff, d}, a);
            else finish_op();
         end
         OP_LDH_C_A: begin
            if (s == 0) schedule(0, KIND_WRITE, {8'hff, reg_rd(3'd1)}, a);
            else finish_op();
         end
         OP_AND_IMM: begin
            if (s == 0) read_pc(0);
            else begin
               load_a_logic(a & d, 1'b1);
               finish_op();
            end
         end
         OP_JUMP_HL: begin
            rp[RP_PC] = rp[RP_HL];
            finish_op();
         end
         OP_STORE_ABS_A: begin
            if (s == 0) read_pc(0);
            else if (s == 1) begin
               op_lo_q = d;
               read_pc(1);
            end else if (s == 2) schedule(2, KIND_WRITE, {d, op_lo_q}, a);
            else finish_op();
         end
         OP_LDH_A_N: begin
            if (s == 0) read_pc(0);
            else if (s == 1) schedule(1, KIND_READ, {8'hff, d}, 8'h00);
            else begin
               reg_wr(3'd7, d);
               finish_op();
            end
         end
         OP_DI: begin
            ie_q = 1'b0;
            finish_op();
         end
         OP_EI: begin
            ie_q = 1'b1;
            finish_op();
         end
         OP_CP_N: begin
            if (s == 0) read_pc(0);
            else begin
               set_flag(FLAG_Z, a == d);
               set_flag(FLAG_N, 1'b1);
               set_flag(FLAG_H, a[3:0] < d[3:0]);
               set_flag(FLAG_C, a < d);
               finish_op();
            end
         end
         default: stop_core();
      endcase
   endtask

   // Complete the pending access and record the result beat it must cause.
   task automatic accept_beat(logic [7:0] d);
      bus_view_type e;
      logic [7:0] data;
      stepped_q = 1'b1;
      if (!halted_q) begin
         data = (kind_q == KIND_READ) ? d : 8'h00;
         if (step_q == 4'd0) begin
            opcode_q  = data;
            rp[RP_PC] = rp[RP_PC] + 16'd1;
            exec_step(4'd0, 8'h00);
         end else begin
            exec_step(step_q, data);
         end
      end
      e.kind  = kind_q;
      e.addr  = (kind_q == KIND_READ || kind_q == KIND_WRITE) ? paddr_q : 16'h0000;
      e.wdata = (kind_q == KIND_WRITE) ? pdata_q : 8'h00;
      e.fetch = !halted_q && step_q == 4'd0;
      e.af = rp[RP_AF];
      e.bc = rp[RP_BC];
      e.de = rp[RP_DE];
      e.hl = rp[RP_HL];
      e.sp = rp[RP_SP];
      e.pc = rp[RP_PC];
      e.ie = ie_q;
      expected_bus.push_back(e);
   endtask

   task automatic compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
         fail_count++;
         $display("%0t: %s mismatch, expected 0x%04h, got 0x%04h", $time, name, exp_v, act_v);
      end
   endtask

   task automatic check_beat(logic [127:0] t);
      bus_view_type e;
      if (expected_bus.size() == 0) begin
         fail_count++;
         $display("%0t: result beat with nothing expected, got 0x%032h", $time, t);
         return;
      end
      e = expected_bus.pop_front();
      compare_field("access_kind", 16'(e.kind), 16'(t[1:0]));
      compare_field("access_address", e.addr, t[17:2]);
      compare_field("write_data", 16'(e.wdata), 16'(t[25:18]));
      compare_field("opcode_fetch", 16'(e.fetch), 16'(t[26]));
      compare_field("reg_af", e.af, t[42:27]);
      compare_field("reg_bc", e.bc, t[58:43]);
      compare_field("reg_de", e.de, t[74:59]);
      compare_field("reg_hl", e.hl, t[90:75]);
      compare_field("reg_sp", e.sp, t[106:91]);
      compare_field("reg_pc", e.pc, t[122:107]);
      compare_field("irq_enabled", 16'(e.ie), 16'(t[123]));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) rp[i] = 16'h0000;
         fail_count = 0;
         ie_q = 1'b0;
         halted_q = 1'b0;
         stepped_q = 1'b0;
         opcode_q = 8'h00;
         op_lo_q = 8'h00;
         start_q = 16'h0000;
         expected_bus.delete();
         finish_op();
      end else begin
         // The start address reloads PC only before the first beat.
         if (csr_wen) begin
            start_q = csr_wdata;
            if (!stepped_q) begin
               rp[RP_PC] = csr_wdata;
               paddr_q   = csr_wdata;
            end
         end
         if (rsp_tvalid && rsp_tready) check_beat(rsp_tdata);
         if (req_tvalid && req_tready) accept_beat(req_tdata);
      end
      waiting       = expected_bus.size();
      next_fetch    = !halted_q && step_q == 4'd0;
      next_read     = !halted_q && kind_q == KIND_READ;
      next_prefixed = !halted_q && opcode_q == OP_PREFIX && step_q == 4'd1;
      core_halted   = halted_q;
   end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the instruction sequencer
// Feeds bus data that forms mostly valid instruction streams, with random
// stalls on both channels, and lets the checker verify every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
   import tb_lrs_ops_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic         csr_wen;
   logic [15:0]  csr_wdata;

   int   fail_count, waiting;
   logic next_fetch, next_read, next_prefixed, core_halted;
   logic quiet_phase;
   logic force_unknown;
   int   cycles = 0;
   logic [7:0] known_ops[$];
   logic [7:0] program_bytes[$];

   lr35902_instruction_sequencer DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   lrs_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .waiting(waiting),
      .next_fetch(next_fetch), .next_read(next_read),
      .next_prefixed(next_prefixed), .core_halted(core_halted)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Opcodes that the core implements.
   function automatic bit op_known(logic [7:0] op);
      if (op == OP_PREFIX) return 1;
      if (op >= 8'h40 && op <= 8'h7f) return !(op >= 8'h70 && op <= 8'h77);
      if (op >= 8'h80 && op <= 8'hbf)
         return op[2:0] != 3'd6 && (op[5:3] == 3'd0 || op[5:3] >= 3'd4 && op[5:3] <= 3'd6);
      if (op < 8'h40) begin
         if (op[3:0] == 4'h1 || op[3:0] == 4'h3 || op[3:0] == 4'hb || op[3:0] == 4'h9)
            return 1;
         if (op[2:0] == 3'd6) return 1;
         return op == OP_NOP || op == OP_INC_C || op == OP_DEC_B || op == OP_DEC_C ||
                op == OP_JR_NZ || op == OP_LOAD_A_HL_INC || op == OP_CPL ||
                op == OP_STORE_HL_DEC;
      end
      if (op[3:0] == 4'h1 || op[3:0] == 4'h5 || op[2:0] == 3'd7) return 1;
      return op == OP_JP || op == OP_RET || op == OP_CALL || op == OP_LDH_N_A ||
             op == OP_LDH_C_A || op == OP_AND_IMM || op == OP_JUMP_HL ||
             op == OP_STORE_ABS_A || op == OP_LDH_A_N || op == OP_DI || op == OP_EI ||
             op == OP_CP_N;
   endfunction

   // Byte for the next beat, chosen from the predicted pending access.
   function automatic logic [7:0] pick_byte();
      logic [7:0] v;
      if (program_bytes.size() != 0 && next_read) return program_bytes.pop_front();
      if (next_fetch && force_unknown) return OP_ILLEGAL;
      if (next_fetch) return known_ops[$urandom_range(0, known_ops.size() - 1)];
      if (next_prefixed) begin
         do v = 8'($urandom_range(0, 255));
         while (!(v == CB_SWAP_A || v >= 8'h40 && v[2:0] != 3'd6));
         return v;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // One input beat, with an occasional burst of idle cycles ahead of it.
   task automatic send_beat();
      int gap;
      gap = (!quiet_phase && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = pick_byte();
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_drained();
      while (waiting != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_start(logic [15:0] v);
      csr_wdata = v;
      csr_wen   = 1'b1;
      @(negedge clock);
      csr_wen = 1'b0;
   endtask

   // Result side stalls in bursts, except in the quiet phase.
   int stall_left;
   always @(negedge clock) begin
      if (reset || quiet_phase) begin
         rsp_tready = 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready = 1'b0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      csr_wen       = 1'b0;
      csr_wdata     = 16'h0000;
      quiet_phase   = 1'b0;
      force_unknown = 1'b0;
      for (int i = 0; i < 256; i++) if (op_known(8'(i))) known_ops.push_back(8'(i));
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Several start addresses before the first beat; the last one starts near
      // the top of memory so that PC wraps.
      write_start(16'hffff);
      write_start(16'h0000);
      write_start(16'hfffe);

      // Directed program: loads, 16-bit add with both carries, ALU flag cases,
      // stack, prefixed ops, I/O page, memory via HL and all control flow.
      program_bytes = '{
         8'h31, 8'hfe, 8'hff,   8'h01, 8'hff, 8'h0f,   8'h21, 8'h01, 8'hf0,   8'h09,
         8'h3e, 8'hff,   8'h06, 8'h01,   8'h80,   8'ha8,   8'hb0,   8'ha1,
         8'hfe, 8'h80,   OP_CPL,   8'hc5,   8'hf1, 8'h3f, 8'h12,
         OP_PREFIX, CB_SWAP_A,   OP_PREFIX, 8'h7f,   OP_PREFIX, 8'h87,   OP_PREFIX, 8'hc1,
         OP_EI,   OP_DI,   OP_LDH_N_A, 8'h80,   OP_LDH_C_A,   OP_LDH_A_N, 8'h10, 8'haa,
         OP_STORE_ABS_A, 8'h00, 8'hc0,   OP_STORE_HL_IMM, 8'h55,   OP_STORE_HL_DEC,
         OP_LOAD_A_HL_INC, 8'h77,   8'h7e, 8'h88,
         OP_INC_C, OP_DEC_B, OP_DEC_C, 8'h03, 8'h0b,
         OP_NOP,   OP_JR_NZ, 8'hfe,   OP_JP, 8'h00, 8'h01,   OP_CALL, 8'h34, 8'h12,
         OP_RET, 8'h00, 8'h02,   8'hef,   OP_JUMP_HL
      };
      while (program_bytes.size() != 0) send_beat();
      wait_drained();

      // After the first beat a start address write is only stored.
      write_start(16'hffff);
      repeat (300) send_beat();
      wait_drained();
      write_start(16'h0000);
      repeat (220) send_beat();

      // No idling at all in the last stretch.
      quiet_phase = 1'b1;
      repeat (100) send_beat();

      // An unimplemented opcode stops the core; later beats must report halted.
      force_unknown = 1'b1;
      while (!core_halted) send_beat();
      repeat (5) send_beat();

      while (waiting != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      $display("Ran a directed instruction mix and about 600 random beats of valid");
      $display("instruction streams with stalls on both sides, ending in a halt.");
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/lrs_pkg.sv
design/lrs_exec.sv
design/lr35902_instruction_sequencer.sv
design/lrs_checker.sv
bench/tb_lrs_ops_pkg.sv
bench/lrs_checker.sv
bench/tb_top.sv
